/* sv/sba_pkg.sv */
// Shared types and constants for the slot bitmap allocator.
// No dependencies; imported by sba_ctrl, sba_datapath and slot_bitmap_allocator.
package sba_pkg;

  localparam int MAP_BITS   = 64;
  localparam int GROUP_BITS = 8;
  localparam int GROUPS     = MAP_BITS / GROUP_BITS;
  localparam int IDX_W      = 6;
  localparam int GLOW_W     = 3;
  localparam int PROD_W     = 22;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic CFG_SIZE = 1'b0;
  localparam logic CFG_BASE = 1'b1;

  typedef struct packed {
    logic load_in;
    logic scan;
    logic pick;
    logic mul;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } stat_t;

endpackage

/* sv/sba_ctrl.sv */
// Sequencer for the slot bitmap allocator: scan, pick, multiply, deliver.
// Depends on sba_pkg; drives the command struct of sba_datapath.
module sba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  input  sba_pkg::stat_t stat,
  output sba_pkg::cmd_t  cmd
);
  import sba_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;
  logic       accept;

  assign out_free = !stat.out_full || out_ready;
  assign in_ready = (state == S_IDLE) || ((state == S_DONE) && out_free);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.load_in  = accept;
    state_next   = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = accept ? S_SCAN : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/sba_datapath.sv */
// Datapath of the slot bitmap allocator: map, two-level free search, address unit.
// Depends on sba_pkg; sequenced by sba_ctrl.
module sba_datapath #(
  parameter int SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  sba_pkg::cmd_t  cmd,
  output sba_pkg::stat_t stat,
  input  logic [1:0]    func,
  input  logic [6:0]    slot_index,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [1:0]    status,
  output logic [5:0]    granted_index,
  output logic [31:0]   slot_address,
  output logic          only_first_used
);
  import sba_pkg::*;

  localparam logic [MAP_BITS-1:0] VALID_MASK =
    MAP_BITS'((65'd1 << SLOTS) - 65'd1);
  localparam logic [6:0] SLOTS_LIM = 7'(SLOTS);

  logic [15:0]            slot_size;
  logic [31:0]            slot_base;
  logic [SLOTS-1:0]       used_map;
  logic [SLOTS-1:0]       used_map_next;
  logic [1:0]             op_func;
  logic [6:0]             op_index;
  logic [GROUPS-1:0]      grp_any;
  logic [GROUPS-1:0][GLOW_W-1:0] grp_low;
  logic [GROUPS-1:0]      grp_any_next;
  logic [GROUPS-1:0][GLOW_W-1:0] grp_low_next;
  logic [MAP_BITS-1:0]    free_bits;
  logic [IDX_W-1:0]       sel;
  logic                   hit;
  logic [1:0]             status_next;
  logic [IDX_W-1:0]       granted_next;
  logic                   granted_ok_next;
  logic [1:0]             res_status;
  logic [IDX_W-1:0]       res_index;
  logic                   res_ok;
  logic                   res_only;
  logic [PROD_W-1:0]      product;

  assign free_bits     = ~MAP_BITS'(used_map) & VALID_MASK;
  assign stat.out_full = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_size <= '0;
      slot_base <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE: slot_size <= cfg_data[15:0];
        CFG_BASE: slot_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_any_next[g] = |free_bits[g*GROUP_BITS +: GROUP_BITS];
      grp_low_next[g] = '0;
      for (int b = GROUP_BITS - 1; b >= 0; b--) begin
        if (free_bits[g*GROUP_BITS + b]) grp_low_next[g] = GLOW_W'(b);
      end
    end
  end

  always_comb begin
    sel = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) sel = {GLOW_W'(g), grp_low[g]};
    end
    hit = |grp_any;
  end

  always_comb begin
    used_map_next   = used_map;
    status_next     = ST_DONE;
    granted_next    = '0;
    granted_ok_next = 1'b0;
    case (op_func)
      FUNC_ALLOC: begin
        if (hit) begin
          granted_next    = sel;
          granted_ok_next = 1'b1;
          for (int i = 0; i < SLOTS; i++) begin
            if (sel == IDX_W'(i)) used_map_next[i] = 1'b1;
          end
        end else begin
          status_next = ST_FULL;
        end
      end
      FUNC_RELEASE: begin
        if (op_index >= SLOTS_LIM) begin
          status_next = ST_RANGE;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (op_index == 7'(i)) used_map_next[i] = 1'b0;
          end
        end
      end
      FUNC_CLEAR: used_map_next = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_map <= '0;
    end else if (cmd.pick) begin
      used_map <= used_map_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_func  <= func;
      op_index <= slot_index;
    end
    if (cmd.scan) begin
      grp_any <= grp_any_next;
      grp_low <= grp_low_next;
    end
    if (cmd.pick) begin
      res_status <= status_next;
      res_index  <= granted_next;
      res_ok     <= granted_ok_next;
    end
    if (cmd.mul) begin
      product  <= PROD_W'(res_index) * PROD_W'(slot_size);
      res_only <= (used_map == SLOTS'(1));
    end
    if (cmd.load_out) begin
      status          <= res_status;
      granted_index   <= res_index;
      slot_address    <= res_ok ? (32'(product) + slot_base) : 32'd0;
      only_first_used <= res_only;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* sv/slot_bitmap_allocator.sv */
// Slot bitmap allocator top level: allocate lowest free slot, release, clear.
// Depends on sba_pkg, sba_ctrl and sba_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries func and slot_index; one beat
//   per operation. Output channel (out_valid/out_ready) returns one beat per
//   operation: status, granted_index, slot_address, only_first_used.
//   Config channel (cfg_valid/cfg_ready) writes slot_size (index 0) or
//   slot_base (index 1); cfg_ready is always high. Write config only idle.
//   Flow: an accepted beat passes the scan, pick and multiply steps of the
//   sequencer, then moves into the output register in the deliver step once
//   that register is free; one operation is in flight at a time, and the next
//   beat is taken in the cycle a result moves into the output register.
//   Output stall: a result waits in the output register; the sequencer holds
//   the following result until that register frees.
//   Reset: map empty, slot_size and slot_base zero, output empty.
module slot_bitmap_allocator #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [6:0]  slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [5:0]  granted_index,
  output logic [31:0] slot_address,
  output logic        only_first_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import sba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  sba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sba_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .func            (func),
    .slot_index      (slot_index),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .status          (status),
    .granted_index   (granted_index),
    .slot_address    (slot_address),
    .only_first_used (only_first_used)
  );

endmodule

/* tb/sv/slot_bitmap_allocator_tb.sv */
`timescale 1ns / 1ps
// Testbench for slot_bitmap_allocator: allocate, release, clear and idle ops under
// random sender gaps and receiver stalls, checked against an in-bench slot map model.
// Depends on sba_pkg and the slot_bitmap_allocator RTL.
module slot_bitmap_allocator_tb;
  import sba_pkg::*;

  localparam int SLOTS = 64;
  localparam logic [63:0] SLOT_MASK = {64{1'b1}} >> (64 - SLOTS);
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int TARGET_OPS = 550;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  localparam int RCV_FLOW    = 0;
  localparam int RCV_PATTERN = 1;
  localparam int RCV_RANDOM  = 2;
  localparam int RCV_CHOKE   = 3;

  localparam int KIND_ALLOC = 0;
  localparam int KIND_FILL  = 1;
  localparam int KIND_MIXED = 2;

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  index;
    logic [31:0] addr;
    logic        first_only;
  } slot_result_t;

  class slot_map_scoreboard;
    logic [63:0]  used_map;
    logic [15:0]  slot_size;
    logic [31:0]  slot_base;
    slot_result_t pending_q[$];
    int           errors;

    function new();
      used_map = '0;
      slot_size = '0;
      slot_base = '0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == CFG_SIZE) slot_size = data[15:0];
      else slot_base = data;
    endfunction

    function void note_op(logic [1:0] f, logic [6:0] idx);
      slot_result_t r;
      logic [63:0]  free_map;
      bit           hit;
      r.status = ST_DONE;
      r.index = '0;
      r.addr = '0;
      hit = 1'b0;
      case (f)
        FUNC_ALLOC: begin
          free_map = ~used_map & SLOT_MASK;
          if (free_map == '0) begin
            r.status = ST_FULL;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!hit && free_map[i]) begin
                hit = 1'b1;
                used_map[i] = 1'b1;
                r.index = 6'(i);
                r.addr = 32'(i) * 32'(slot_size) + slot_base;
              end
            end
          end
        end
        FUNC_RELEASE: begin
          if (idx >= SLOTS) r.status = ST_RANGE;
          else used_map[idx[5:0]] = 1'b0;
        end
        FUNC_CLEAR: used_map = '0;
        default: ;
      endcase
      r.first_only = (used_map == 64'd1);
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [5:0] gi, logic [31:0] addr, logic fo);
      slot_result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual status %0d index %0d addr %h",
                 $time, st, gi, addr);
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
      end
      if (gi !== e.index) begin
        errors++;
        $display("%0t: granted_index expected %0d actual %0d", $time, e.index, gi);
      end
      if (addr !== e.addr) begin
        errors++;
        $display("%0t: slot_address expected %h actual %h", $time, e.addr, addr);
      end
      if (fo !== e.first_only) begin
        errors++;
        $display("%0t: only_first_used expected %0d actual %0d", $time, e.first_only, fo);
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = FUNC_ALLOC;
  logic [6:0]  slot_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [5:0]  granted_index;
  logic [31:0] slot_address;
  logic        only_first_used;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_SIZE;
  logic [31:0] cfg_data = '0;

  slot_map_scoreboard sb;
  int         ops_sent = 0;
  int         burst_left = 0;
  bit         gaps_on = 1'b1;
  int         rcv_mode = RCV_FLOW;
  logic [7:0] stall_pat = 8'hFF;
  logic [2:0] pat_pos = '0;
  int         idle_cycles = 0;

  slot_bitmap_allocator #(.SLOTS(SLOTS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .slot_index(slot_index),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .granted_index(granted_index), .slot_address(slot_address),
    .only_first_used(only_first_used),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_op(func, slot_index);
    if (!rst && out_valid && out_ready)
      sb.check_result(status, granted_index, slot_address, only_first_used);
    if (!rst && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      case (rcv_mode)
        RCV_FLOW: out_ready <= 1'b1;
        RCV_PATTERN: begin
          out_ready <= stall_pat[pat_pos];
          pat_pos <= pat_pos + 3'd1;
        end
        RCV_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog: any beat on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_op(input logic [1:0] f, input logic [6:0] idx);
    in_valid <= 1'b1;
    func <= f;
    slot_index <= idx;
    do @(posedge clk); while (!in_ready);
    ops_sent++;
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(0, 7);
    end
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [6:0] used_slot();
    int k;
    for (int t = 0; t < 16; t++) begin
      k = $urandom_range(0, SLOTS - 1);
      if (sb.used_map[k]) return 7'(k);
    end
    return 7'($urandom_range(0, SLOTS - 1));
  endfunction

  task automatic pick_op(input int kind, output logic [1:0] f, output logic [6:0] idx);
    int r;
    r = $urandom_range(0, 99);
    idx = 7'($urandom_range(0, 127));
    if (kind == KIND_ALLOC) begin
      if (r < 65) f = FUNC_ALLOC;
      else if (r < 85) begin f = FUNC_RELEASE; idx = used_slot(); end
      else if (r < 90) begin f = FUNC_RELEASE; idx = 7'($urandom_range(SLOTS, 127)); end
      else if (r < 93) begin f = FUNC_RELEASE; idx = 7'($urandom_range(0, SLOTS - 1)); end
      else if (r < 96) f = FUNC_CLEAR;
      else f = FUNC_NOP;
    end else begin
      if (r < 40) f = FUNC_ALLOC;
      else if (r < 75) begin f = FUNC_RELEASE; idx = used_slot(); end
      else if (r < 82) begin f = FUNC_RELEASE; idx = 7'($urandom_range(0, SLOTS - 1)); end
      else if (r < 88) begin f = FUNC_RELEASE; idx = 7'($urandom_range(SLOTS, 127)); end
      else if (r < 93) f = FUNC_CLEAR;
      else f = FUNC_NOP;
    end
  endtask

  task automatic run_phase(input int phase);
    logic [15:0] size;
    logic [31:0] base;
    logic [1:0]  f;
    logic [6:0]  idx;
    int          kind;
    int          count;
    case (phase % 6)
      0: begin size = 16'h0000; base = 32'h0000_0000; end
      1: begin size = 16'hFFFF; base = 32'hFFFF_FFFF; end
      2: begin size = 16'($urandom); base = $urandom; end
      3: begin size = 16'h0001; base = 32'hFFFF_FFF0; end
      4: begin size = 16'h8000; base = 32'h8000_0000; end
      default: begin size = 16'($urandom_range(0, 255)); base = $urandom; end
    endcase
    write_reg(CFG_SIZE, {16'($urandom), size});
    write_reg(CFG_BASE, base);
    rcv_mode = $urandom_range(RCV_FLOW, RCV_CHOKE);
    stall_pat = 8'($urandom) | 8'h01;
    gaps_on = ($urandom_range(0, 3) != 0);
    burst_left = $urandom_range(0, 7);
    kind = phase % 3;
    if (kind == KIND_FILL) begin
      send_op(FUNC_CLEAR, 7'($urandom_range(0, 127)));
      repeat (SLOTS + 2) send_op(FUNC_ALLOC, 7'($urandom_range(0, 127)));
      count = $urandom_range(8, 16);
      kind = KIND_MIXED;
    end else begin
      count = $urandom_range(30, 70);
    end
    repeat (count) begin
      pick_op(kind, f, idx);
      send_op(f, idx);
    end
    drain();
  endtask

  initial begin
    int phase;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(CFG_SIZE, 32'h0000_0040);
    write_reg(CFG_BASE, 32'h0001_0000);
    send_op(FUNC_ALLOC, 7'h00);
    send_op(FUNC_ALLOC, 7'h7F);
    send_op(FUNC_ALLOC, 7'h2A);
    send_op(FUNC_RELEASE, 7'd1);
    send_op(FUNC_ALLOC, 7'h55);
    send_op(FUNC_RELEASE, 7'd64);
    send_op(FUNC_RELEASE, 7'd127);
    send_op(FUNC_RELEASE, 7'd40);
    send_op(FUNC_NOP, 7'h00);
    send_op(FUNC_RELEASE, 7'd2);
    send_op(FUNC_RELEASE, 7'd1);
    send_op(FUNC_RELEASE, 7'd0);
    send_op(FUNC_CLEAR, 7'h00);
    send_op(FUNC_ALLOC, 7'h00);
    send_op(FUNC_RELEASE, 7'd63);
    send_op(FUNC_CLEAR, 7'h7F);
    send_op(FUNC_NOP, 7'h7F);
    drain();

    phase = 0;
    while (ops_sent < TARGET_OPS) begin
      run_phase(phase);
      phase++;
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
